// ===== hw/rtl/ppt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppt_pkg
// shared widths, codes, packet type and clamp function of the pointer
// packet tracker
// ----------------------------------------------------------------------------
package ppt_pkg;

    localparam int COORD_BITS   = 12;
    localparam int SIZE_BITS    = 13;
    localparam int BYTE_BITS    = 8;
    localparam int CFG_IDX_BITS = 8;
    localparam int SUM_BITS     = COORD_BITS + 2;
    localparam int CMP_BITS     = (COORD_BITS + 1 > SIZE_BITS) ? COORD_BITS + 1 : SIZE_BITS;

    localparam logic [CMP_BITS-1:0]  COORD_SPAN    = CMP_BITS'(1) << COORD_BITS;
    localparam logic [SIZE_BITS-1:0] WIDTH_RESET   = SIZE_BITS'(1024);
    localparam logic [SIZE_BITS-1:0] HEIGHT_RESET  = SIZE_BITS'(768);
    localparam int                   LEFT_BIT      = 0;

    // register indexes on the config port
    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = CFG_IDX_BITS'(1);

    // position of a byte inside a packet
    localparam logic [1:0] IDX_HEADER = 2'd0;
    localparam logic [1:0] IDX_XDELTA = 2'd1;
    localparam logic [1:0] IDX_YDELTA = 2'd2;

    typedef struct packed {
        logic [BYTE_BITS-1:0] header;
        logic [BYTE_BITS-1:0] x_delta;
        logic [BYTE_BITS-1:0] y_delta;
    } pkt_t;

    // limit a signed sum to [0, size-1], size 0 acting as 1 and
    // sizes above the coordinate span acting as the span
    function automatic logic [COORD_BITS-1:0] clamp_coord(
        input logic signed [SUM_BITS-1:0] v,
        input logic [SIZE_BITS-1:0]       size
    );
        logic [CMP_BITS-1:0]   size_ext;
        logic [COORD_BITS-1:0] max_c;
        logic [COORD_BITS:0]   mag;
        size_ext = CMP_BITS'(size);
        if (size_ext == '0)
            max_c = '0;
        else if (size_ext > COORD_SPAN)
            max_c = '1;
        else
            max_c = COORD_BITS'(size_ext - CMP_BITS'(1));
        mag = v[SUM_BITS-2:0];
        if (v[SUM_BITS-1])
            return '0;
        else if (mag > (COORD_BITS + 1)'(max_c))
            return max_c;
        else
            return mag[COORD_BITS-1:0];
    endfunction

endpackage

// ===== hw/rtl/ppt_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppt_if
// valid/ready channels of the pointer packet tracker: raw device bytes,
// cursor reports and configuration writes
// ----------------------------------------------------------------------------
interface ppt_byte_if;
    logic                            valid;
    logic                            ready;
    logic [ppt_pkg::BYTE_BITS-1:0]   data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface ppt_report_if;
    logic                            valid;
    logic                            ready;
    logic [ppt_pkg::COORD_BITS-1:0]  cursor_x;
    logic [ppt_pkg::COORD_BITS-1:0]  cursor_y;
    logic                            left_pressed;
    logic                            click;
    logic [ppt_pkg::COORD_BITS-1:0]  click_x;
    logic [ppt_pkg::COORD_BITS-1:0]  click_y;

    modport source (output valid, output cursor_x, output cursor_y, output left_pressed,
                    output click, output click_x, output click_y, input ready);
    modport sink   (input valid, input cursor_x, input cursor_y, input left_pressed,
                    input click, input click_x, input click_y, output ready);
endinterface

interface ppt_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [ppt_pkg::CFG_IDX_BITS-1:0]  reg_index;
    logic [ppt_pkg::SIZE_BITS-1:0]     wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ===== hw/rtl/pointer_packet_tracker_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pointer_packet_tracker_core
// groups pointing-device bytes into three-byte packets and tracks a
// clamped cursor with left-click detection
// ----------------------------------------------------------------------------
// report path: the third byte of a packet is accepted into the packet
//   register, then the packet moves to the report register and shows valid
// throughput: one byte per cycle; a stalled report only holds back the
//   third byte of the next packet
// reset: byte position, cursor, button history and report valid clear;
//   screen size returns to 1024 x 768
module pointer_packet_tracker_core (
    input  logic            clk,
    input  logic            rst_n,
    ppt_byte_if.sink        dev,
    ppt_report_if.source    cursor,
    ppt_cfg_if.sink         cfg
);

    // packet handoff between the byte collector and the tracker
    logic           pkt_valid;
    logic           pkt_take;
    ppt_pkg::pkt_t  pkt;

    // header, x delta and y delta land in one packet register
    ppt_assembler u_assembler (
        .clk       (clk),
        .rst_n     (rst_n),
        .dev       (dev),
        .pkt_valid (pkt_valid),
        .pkt       (pkt),
        .pkt_take  (pkt_take)
    );

    // cursor add/subtract, clamp to screen, click edge and report register
    ppt_tracker u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .pkt_valid (pkt_valid),
        .pkt       (pkt),
        .pkt_take  (pkt_take),
        .cursor    (cursor)
    );

endmodule

// ===== hw/rtl/ppt_assembler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppt_assembler
// collects three device bytes into a packet register
// ----------------------------------------------------------------------------
module ppt_assembler (
    input  logic                clk,
    input  logic                rst_n,
    ppt_byte_if.sink            dev,
    output logic                pkt_valid,
    output ppt_pkg::pkt_t       pkt,
    input  logic                pkt_take
);

    logic [1:0]                     byte_index_reg;
    logic [1:0]                     byte_index_next;
    logic [ppt_pkg::BYTE_BITS-1:0]  header_reg;
    logic [ppt_pkg::BYTE_BITS-1:0]  x_delta_reg;
    logic                           pkt_valid_reg;
    logic                           pkt_valid_next;
    ppt_pkg::pkt_t                  pkt_reg;
    logic                           accept;
    logic                           last_byte;

    // only the closing byte needs room in the packet register
    assign last_byte = (byte_index_reg == ppt_pkg::IDX_YDELTA);
    assign dev.ready = !last_byte || !pkt_valid_reg || pkt_take;
    assign accept    = dev.valid && dev.ready;

    always_comb
    begin
        byte_index_next = byte_index_reg;
        pkt_valid_next  = pkt_valid_reg && !pkt_take;
        if (accept)
        begin
            unique case (byte_index_reg)
                ppt_pkg::IDX_XDELTA: byte_index_next = ppt_pkg::IDX_YDELTA;
                ppt_pkg::IDX_YDELTA:
                begin
                    byte_index_next = ppt_pkg::IDX_HEADER;
                    pkt_valid_next  = 1'b1;
                end
                default:             byte_index_next = ppt_pkg::IDX_XDELTA;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= ppt_pkg::IDX_HEADER;
            header_reg     <= '0;
            x_delta_reg    <= '0;
            pkt_valid_reg  <= 1'b0;
        end
        else
        begin
            byte_index_reg <= byte_index_next;
            pkt_valid_reg  <= pkt_valid_next;
            if (accept && byte_index_reg == ppt_pkg::IDX_XDELTA)
                x_delta_reg <= dev.data_byte;
            else if (accept && !last_byte)
                header_reg <= dev.data_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && last_byte)
        begin
            pkt_reg.header  <= header_reg;
            pkt_reg.x_delta <= x_delta_reg;
            pkt_reg.y_delta <= dev.data_byte;
        end
    end

    assign pkt_valid = pkt_valid_reg;
    assign pkt       = pkt_reg;

endmodule

// ===== hw/rtl/ppt_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppt_tracker
// screen size registers, cursor update with clamp, click detect and
// the report register
// ----------------------------------------------------------------------------
module ppt_tracker (
    input  logic                clk,
    input  logic                rst_n,
    ppt_cfg_if.sink             cfg,
    input  logic                pkt_valid,
    input  ppt_pkg::pkt_t       pkt,
    output logic                pkt_take,
    ppt_report_if.source        cursor
);

    logic [ppt_pkg::SIZE_BITS-1:0]          width_reg;
    logic [ppt_pkg::SIZE_BITS-1:0]          height_reg;
    logic [ppt_pkg::COORD_BITS-1:0]         pos_x_reg;
    logic [ppt_pkg::COORD_BITS-1:0]         pos_y_reg;
    logic [ppt_pkg::COORD_BITS-1:0]         pos_x_next;
    logic [ppt_pkg::COORD_BITS-1:0]         pos_y_next;
    logic                                   prev_left_reg;
    logic                                   out_valid_reg;
    logic                                   left;
    logic                                   edge_hit;
    logic signed [ppt_pkg::SUM_BITS-1:0]    sum_x;
    logic signed [ppt_pkg::SUM_BITS-1:0]    sum_y;
    logic [ppt_pkg::COORD_BITS-1:0]         cur_x_reg;
    logic [ppt_pkg::COORD_BITS-1:0]         cur_y_reg;
    logic                                   left_reg;
    logic                                   click_reg;
    logic [ppt_pkg::COORD_BITS-1:0]         click_x_reg;
    logic [ppt_pkg::COORD_BITS-1:0]         click_y_reg;

    assign cfg.ready = 1'b1;
    assign pkt_take  = pkt_valid && (!out_valid_reg || cursor.ready);

    assign left     = pkt.header[ppt_pkg::LEFT_BIT];
    assign edge_hit = left && !prev_left_reg;

    // x gains the delta, y loses it
    assign sum_x = $signed({2'b00, pos_x_reg})
                 + $signed({{(ppt_pkg::SUM_BITS - ppt_pkg::BYTE_BITS){pkt.x_delta[7]}},
                            pkt.x_delta});
    assign sum_y = $signed({2'b00, pos_y_reg})
                 - $signed({{(ppt_pkg::SUM_BITS - ppt_pkg::BYTE_BITS){pkt.y_delta[7]}},
                            pkt.y_delta});

    assign pos_x_next = ppt_pkg::clamp_coord(sum_x, width_reg);
    assign pos_y_next = ppt_pkg::clamp_coord(sum_y, height_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= ppt_pkg::WIDTH_RESET;
            height_reg    <= ppt_pkg::HEIGHT_RESET;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            prev_left_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.reg_index == ppt_pkg::REG_SCREEN_WIDTH)
                width_reg <= cfg.wdata;
            if (cfg.valid && cfg.reg_index == ppt_pkg::REG_SCREEN_HEIGHT)
                height_reg <= cfg.wdata;
            if (pkt_take)
            begin
                pos_x_reg     <= pos_x_next;
                pos_y_reg     <= pos_y_next;
                prev_left_reg <= left;
                out_valid_reg <= 1'b1;
            end
            else if (cursor.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pkt_take)
        begin
            cur_x_reg   <= pos_x_next;
            cur_y_reg   <= pos_y_next;
            left_reg    <= left;
            click_reg   <= edge_hit;
            click_x_reg <= edge_hit ? pos_x_reg : '0;
            click_y_reg <= edge_hit ? pos_y_reg : '0;
        end
    end

    assign cursor.valid        = out_valid_reg;
    assign cursor.cursor_x     = cur_x_reg;
    assign cursor.cursor_y     = cur_y_reg;
    assign cursor.left_pressed = left_reg;
    assign cursor.click        = click_reg;
    assign cursor.click_x      = click_x_reg;
    assign cursor.click_y      = click_y_reg;

endmodule

// ===== hw/rtl/ppt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppt_checker
// port-level checks on the cursor report channel
// ----------------------------------------------------------------------------
module ppt_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [ppt_pkg::COORD_BITS-1:0]  cursor_x,
    input  logic [ppt_pkg::COORD_BITS-1:0]  cursor_y,
    input  logic                            left_pressed,
    input  logic                            click,
    input  logic [ppt_pkg::COORD_BITS-1:0]  click_x,
    input  logic [ppt_pkg::COORD_BITS-1:0]  click_y
);

    // no report may be pending while in reset
    a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("report valid during reset");

    // a stalled report keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cursor_x) && $stable(cursor_y)
            && $stable(click) && $stable(click_x) && $stable(click_y))
        else $error("stalled report changed");

    // a click is only reported with the button down
    a_click_pressed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && click |-> left_pressed)
        else $error("click without left pressed");

    // click position is zero when no click
    a_click_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !click |-> click_x == '0 && click_y == '0)
        else $error("click position set without click");

endmodule

bind pointer_packet_tracker_core ppt_checker u_ppt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (cursor.valid),
    .out_ready    (cursor.ready),
    .cursor_x     (cursor.cursor_x),
    .cursor_y     (cursor.cursor_y),
    .left_pressed (cursor.left_pressed),
    .click        (cursor.click),
    .click_x      (cursor.click_x),
    .click_y      (cursor.click_y)
);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// checks the pointer packet tracker end to end. A software tracker follows
// every accepted device byte and queues the expected cursor report. Each
// report taken from the block is compared field by field with the oldest
// entry. Screen sizes are swept between phases, the extremes among them.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 4;

    // config indexes that the block must ignore
    localparam logic [ppt_pkg::CFG_IDX_BITS-1:0] REG_UNUSED_LOW  =
        ppt_pkg::REG_SCREEN_HEIGHT + 1'b1;
    localparam logic [ppt_pkg::CFG_IDX_BITS-1:0] REG_UNUSED_HIGH = '1;

    // one expected cursor report
    typedef struct packed {
        logic [ppt_pkg::COORD_BITS-1:0] cursor_x;
        logic [ppt_pkg::COORD_BITS-1:0] cursor_y;
        logic                           left_pressed;
        logic                           click;
        logic [ppt_pkg::COORD_BITS-1:0] click_x;
        logic [ppt_pkg::COORD_BITS-1:0] click_y;
    } report_t;

    logic clk = 1'b0;
    logic rst_n;

    ppt_byte_if   dev_bus();
    ppt_report_if rpt_bus();
    ppt_cfg_if    cfg_bus();

    pointer_packet_tracker_core uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .dev    (dev_bus),
        .cursor (rpt_bus),
        .cfg    (cfg_bus)
    );

    always #6 clk = ~clk;

    // expected reports, oldest first
    report_t pending_reports[$];
    report_t want;
    int      errors      = 0;
    int      cycle_count = 0;
    int      stall_left  = 0;
    bit      gaps_on;
    bit      stalls_on;

    // software copy of the tracker state
    logic [1:0]                    pkt_pos;
    logic [ppt_pkg::BYTE_BITS-1:0] hdr_q;
    logic [ppt_pkg::BYTE_BITS-1:0] dx_q;
    int                            cur_x;
    int                            cur_y;
    logic                          left_q;
    logic [ppt_pkg::SIZE_BITS-1:0] scr_w;
    logic [ppt_pkg::SIZE_BITS-1:0] scr_h;

    // hard stop in case the block hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // report side back-pressure in random bursts
    always @(negedge clk)
    begin
        if (stall_left == 0 && stalls_on && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 12);
        if (stall_left > 0)
        begin
            stall_left--;
            rpt_bus.ready <= 1'b0;
        end
        else
            rpt_bus.ready <= 1'b1;
    end

    // size 0 acts as 1, sizes past the coordinate span act as the span
    function automatic logic [ppt_pkg::COORD_BITS-1:0] fit_to_screen(
        input int v,
        input logic [ppt_pkg::SIZE_BITS-1:0] size
    );
        int lim;
        lim = int'(size);
        if (lim < 1)
            lim = 1;
        if (lim > (1 << ppt_pkg::COORD_BITS))
            lim = 1 << ppt_pkg::COORD_BITS;
        if (v < 0)
            return '0;
        if (v >= lim)
            return (ppt_pkg::COORD_BITS)'(lim - 1);
        return (ppt_pkg::COORD_BITS)'(v);
    endfunction

    function automatic void reset_tracker();
        pkt_pos = ppt_pkg::IDX_HEADER;
        hdr_q   = '0;
        dx_q    = '0;
        cur_x   = 0;
        cur_y   = 0;
        left_q  = 1'b0;
        scr_w   = ppt_pkg::WIDTH_RESET;
        scr_h   = ppt_pkg::HEIGHT_RESET;
    endfunction

    // advance the tracker by one accepted byte, queue a report on the third
    function automatic void track_byte(input logic [ppt_pkg::BYTE_BITS-1:0] b);
        report_t r;
        logic    left;
        int      dx;
        int      dy;
        case (pkt_pos)
            ppt_pkg::IDX_XDELTA:
            begin
                dx_q    = b;
                pkt_pos = ppt_pkg::IDX_YDELTA;
            end
            ppt_pkg::IDX_YDELTA:
            begin
                pkt_pos = ppt_pkg::IDX_HEADER;
                left    = hdr_q[ppt_pkg::LEFT_BIT];
                dx      = $signed(dx_q);
                dy      = $signed(b);
                r.left_pressed = left;
                r.click        = left && !left_q;
                r.click_x      = r.click ? (ppt_pkg::COORD_BITS)'(cur_x) : '0;
                r.click_y      = r.click ? (ppt_pkg::COORD_BITS)'(cur_y) : '0;
                left_q         = left;
                cur_x          = fit_to_screen(cur_x + dx, scr_w);
                cur_y          = fit_to_screen(cur_y - dy, scr_h);
                r.cursor_x     = (ppt_pkg::COORD_BITS)'(cur_x);
                r.cursor_y     = (ppt_pkg::COORD_BITS)'(cur_y);
                pending_reports.push_back(r);
            end
            default:
            begin
                hdr_q   = b;
                pkt_pos = ppt_pkg::IDX_XDELTA;
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input int exp_v, input int got_v);
        if (exp_v != got_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            errors++;
        end
    endfunction

    // report checker
    always @(posedge clk)
    begin
        if (rst_n && rpt_bus.valid && rpt_bus.ready)
        begin
            if (pending_reports.size() == 0)
            begin
                $error("cursor report with nothing expected");
                errors++;
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("cursor_x", want.cursor_x, rpt_bus.cursor_x);
                check_field("cursor_y", want.cursor_y, rpt_bus.cursor_y);
                check_field("left_pressed", want.left_pressed, rpt_bus.left_pressed);
                check_field("click", want.click, rpt_bus.click);
                check_field("click_x", want.click_x, rpt_bus.click_x);
                check_field("click_y", want.click_y, rpt_bus.click_y);
            end
        end
    end

    // push one device byte through the handshake
    task automatic send_byte(input logic [ppt_pkg::BYTE_BITS-1:0] b);
        int gap;
        @(negedge clk);
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 12);
            dev_bus.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        dev_bus.valid     = 1'b1;
        dev_bus.data_byte = b;
        do
            @(posedge clk);
        while (!dev_bus.ready);
        track_byte(b);
    endtask

    task automatic write_reg(input logic [ppt_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [ppt_pkg::SIZE_BITS-1:0] value);
        @(negedge clk);
        cfg_bus.valid     = 1'b1;
        cfg_bus.reg_index = idx;
        cfg_bus.wdata     = value;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        if (idx == ppt_pkg::REG_SCREEN_WIDTH)
            scr_w = value;
        else if (idx == ppt_pkg::REG_SCREEN_HEIGHT)
            scr_h = value;
        @(negedge clk);
        cfg_bus.valid = 1'b0;
    endtask

    // stop sending, wait for every report, then let the pipeline empty
    task automatic settle_idle();
        @(negedge clk);
        dev_bus.valid = 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // a large delta toward the max or min end of an axis
    function automatic logic [ppt_pkg::BYTE_BITS-1:0] drift_byte(input bit up);
        if (up)
            return (ppt_pkg::BYTE_BITS)'($urandom_range(100, 127));
        return (ppt_pkg::BYTE_BITS)'(256 - $urandom_range(100, 128));
    endfunction

    // packets that mostly push the cursor to one corner, with random
    // headers; now and then a stray byte slips the packet framing
    task automatic run_drift_phase(input logic [ppt_pkg::SIZE_BITS-1:0] w,
                                   input logic [ppt_pkg::SIZE_BITS-1:0] h,
                                   input bit load, input bit toward_max,
                                   input int packets);
        logic [ppt_pkg::BYTE_BITS-1:0] hdr;
        logic [ppt_pkg::BYTE_BITS-1:0] dx;
        logic [ppt_pkg::BYTE_BITS-1:0] dy;
        settle_idle();
        if (load)
        begin
            write_reg(ppt_pkg::REG_SCREEN_WIDTH, w);
            write_reg(ppt_pkg::REG_SCREEN_HEIGHT, h);
        end
        repeat (packets)
        begin
            hdr = (ppt_pkg::BYTE_BITS)'($urandom_range(0, 255));
            dx  = ($urandom_range(0, 3) != 0) ? drift_byte(toward_max)
                                              : (ppt_pkg::BYTE_BITS)'($urandom_range(0, 255));
            // y grows with a negative delta
            dy  = ($urandom_range(0, 3) != 0) ? drift_byte(!toward_max)
                                              : (ppt_pkg::BYTE_BITS)'($urandom_range(0, 255));
            send_byte(hdr);
            send_byte(dx);
            send_byte(dy);
            if ($urandom_range(0, 39) == 0)
                send_byte((ppt_pkg::BYTE_BITS)'($urandom_range(0, 255)));
        end
    endtask

    // delta extremes, left press, hold, release and other header bits
    task automatic test_basic_packets();
        // press at the origin, full right, full down
        send_byte(8'h01);
        send_byte(8'h7F);
        send_byte(8'h80);
        // all header bits set: held, no new click; x falls below zero
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h7F);
        // release, no movement
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h00);
        // left bit clear with the rest set, small moves into the corner
        send_byte(8'hFE);
        send_byte(8'hFF);
        send_byte(8'h01);
        // press again
        send_byte(8'h01);
        send_byte(8'h05);
        send_byte(8'hFB);
        settle_idle();
    endtask

    // one-pixel and zero-sized screens, writes to unused indexes
    task automatic test_degenerate_screens();
        write_reg(ppt_pkg::REG_SCREEN_WIDTH, (ppt_pkg::SIZE_BITS)'(1));
        write_reg(ppt_pkg::REG_SCREEN_HEIGHT, (ppt_pkg::SIZE_BITS)'(1));
        write_reg(REG_UNUSED_LOW, '0);
        write_reg(REG_UNUSED_HIGH, '1);
        send_byte(8'h00);
        send_byte(8'h7F);
        send_byte(8'h80);
        settle_idle();
        write_reg(ppt_pkg::REG_SCREEN_WIDTH, '0);
        write_reg(ppt_pkg::REG_SCREEN_HEIGHT, '0);
        send_byte(8'h01);
        send_byte(8'h40);
        send_byte(8'hC0);
        settle_idle();
    endtask

    // back to reset size first, so the reset screen clamps get exercised
    task automatic test_default_screen();
        write_reg(ppt_pkg::REG_SCREEN_WIDTH, ppt_pkg::WIDTH_RESET);
        write_reg(ppt_pkg::REG_SCREEN_HEIGHT, ppt_pkg::HEIGHT_RESET);
        run_drift_phase('0, '0, 1'b0, 1'b1, 33);
    endtask

    // sizes across the register range, each phase pushed to a corner
    task automatic test_register_sweep();
        run_drift_phase((ppt_pkg::SIZE_BITS)'(8191), (ppt_pkg::SIZE_BITS)'(4097),
                        1'b1, 1'b1, 50);
        run_drift_phase((ppt_pkg::SIZE_BITS)'(4096), (ppt_pkg::SIZE_BITS)'(4096),
                        1'b1, 1'b0, 50);
        run_drift_phase((ppt_pkg::SIZE_BITS)'(4097), (ppt_pkg::SIZE_BITS)'(8191),
                        1'b1, 1'b1, 50);
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        run_drift_phase((ppt_pkg::SIZE_BITS)'(1), (ppt_pkg::SIZE_BITS)'(4096),
                        1'b1, 1'b0, 30);
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        run_drift_phase((ppt_pkg::SIZE_BITS)'(640), (ppt_pkg::SIZE_BITS)'(480),
                        1'b1, 1'b1, 30);
        run_drift_phase((ppt_pkg::SIZE_BITS)'(0), (ppt_pkg::SIZE_BITS)'(2),
                        1'b1, 1'b0, 30);
        run_drift_phase((ppt_pkg::SIZE_BITS)'($urandom_range(1, 4096)),
                        (ppt_pkg::SIZE_BITS)'($urandom_range(1, 4096)), 1'b1, 1'b1, 20);
        run_drift_phase((ppt_pkg::SIZE_BITS)'($urandom_range(0, 8191)),
                        (ppt_pkg::SIZE_BITS)'($urandom_range(0, 8191)), 1'b1, 1'b0, 20);
    endtask

    // full-rate traffic with no gaps and no stalls
    task automatic test_steady_stream();
        int n;
        settle_idle();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        write_reg(ppt_pkg::REG_SCREEN_WIDTH, (ppt_pkg::SIZE_BITS)'(800));
        write_reg(ppt_pkg::REG_SCREEN_HEIGHT, (ppt_pkg::SIZE_BITS)'(600));
        for (n = 0; n < 60; n++)
            send_byte((ppt_pkg::BYTE_BITS)'($urandom_range(0, 255)));
        @(negedge clk);
        dev_bus.valid = 1'b0;
    endtask

    initial
    begin
        rst_n             = 1'b0;
        dev_bus.valid     = 1'b0;
        dev_bus.data_byte = '0;
        cfg_bus.valid     = 1'b0;
        cfg_bus.reg_index = '0;
        cfg_bus.wdata     = '0;
        rpt_bus.ready     = 1'b1;
        gaps_on           = 1'b1;
        stalls_on         = 1'b1;
        reset_tracker();
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        test_basic_packets();
        test_degenerate_screens();
        test_default_screen();
        test_register_sweep();
        test_steady_stream();

        // drain and give the pipeline time to show anything extra
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
